FILE: hdl/shiprr_pkg.sv
// ----------------------------------------------------------------------------
// shiprr_pkg
// Types and fixed constants shared by the replacement policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package shiprr_pkg;

	// request transaction
	typedef struct packed {
		logic        mode;
		logic [10:0] set_index;
		logic [3:0]  way_index;
		logic [5:0]  pc_signature;
		logic [7:0]  line_hash;
		logic [63:0] line_address;
		logic        was_hit;
	} req_t;

	// result transaction
	typedef struct packed {
		logic [3:0] victim_way;
		logic       set_streaming;
		logic [1:0] inserted_rrpv;
	} res_t;

	// controller to datapath commands
	typedef struct packed {
		logic latch;
		logic sweep_go;
		logic rd;
		logic victim_fin;
		logic upd_s1;
		logic upd_fin;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic mode_upd;
		logic decay_due;
		logic eng_busy;
	} stat_t;

	localparam logic [7:0]  REG_DECAY_PERIOD = 8'd0;
	localparam logic [7:0]  REG_STREAM_THR   = 8'd1;
	localparam logic [31:0] DECAY_PERIOD_RST = 32'd100000;
	localparam logic [2:0]  STREAM_THR_RST   = 3'd5;

	localparam logic [1:0] RRPV_DISTANT = 2'd3;
	localparam logic [1:0] RRPV_LONG    = 2'd2;
	localparam logic [1:0] RRPV_NEAR    = 2'd0;
	localparam logic [1:0] CTR_MAX      = 2'd3;
	localparam logic [1:0] CTR_HOT      = 2'd2;
	localparam logic [2:0] STREAM_MAX   = 3'd7;
	localparam logic       MODE_UPDATE  = 1'b1;

endpackage

`default_nettype wire

FILE: hdl/shiprr_ctrl.sv
// ----------------------------------------------------------------------------
// shiprr_ctrl
// Sequencer: reset clear, request dispatch, decay sweep, read and write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module shiprr_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  shiprr_pkg::stat_t   stat,
	output shiprr_pkg::cmd_t    cmd
);
	import shiprr_pkg::*;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DISP  = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_DATA  = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLR: begin
				if (!stat.eng_busy) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				if (stat.mode_upd && stat.decay_due) begin
					cmd.sweep_go = 1'b1;
					state_d      = S_SWEEP;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_DATA;
				end
			end
			S_SWEEP: begin
				if (!stat.eng_busy) begin
					cmd.rd  = 1'b1;
					state_d = S_DATA;
				end
			end
			S_DATA: begin
				if (stat.mode_upd) begin
					cmd.upd_s1 = 1'b1;
					state_d    = S_FIN;
				end else begin
					cmd.victim_fin = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_FIN: begin
				cmd.upd_fin = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_CLR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

FILE: hdl/shiprr_dpath.sv
// ----------------------------------------------------------------------------
// shiprr_dpath
// Line, set and signature stores, sweep engine, victim and insertion logic.
// ----------------------------------------------------------------------------
`default_nettype none

module shiprr_dpath #(
	parameter int NUM_SETS  = 2048,
	parameter int NUM_WAYS  = 16,
	parameter int SIG_BITS  = 6,
	parameter int HASH_BITS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  shiprr_pkg::req_t    req,
	input  shiprr_pkg::cmd_t    cmd,
	output shiprr_pkg::stat_t   stat,
	input  wire                 cfg_we,
	input  wire  [7:0]          cfg_index,
	input  wire  [31:0]         cfg_data,
	output logic                result_valid,
	output shiprr_pkg::res_t    result
);
	import shiprr_pkg::*;

	localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W     = $clog2(NUM_WAYS);
	localparam int NUM_SIGS  = 1 << SIG_BITS;
	localparam int SWEEP_LEN = (NUM_SETS > NUM_SIGS) ? NUM_SETS : NUM_SIGS;
	localparam int CNT_W     = $clog2(SWEEP_LEN + 1);

	// reduce a narrow index modulo n, one shifted subtract per bit
	function automatic logic [31:0] red_mod(input logic [10:0] v, input int n);
		logic [31:0] r;
		r = {21'b0, v};
		for (int i = 10; i >= 0; i--) begin
			if (r >= (32'(n) << i)) r = r - (32'(n) << i);
		end
		return r;
	endfunction

	// configuration
	logic [31:0] period_q;
	logic [2:0]  thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= DECAY_PERIOD_RST;
			thr_q    <= STREAM_THR_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_DECAY_PERIOD) period_q <= cfg_data;
			if (cfg_index == REG_STREAM_THR)   thr_q    <= cfg_data[2:0];
		end
	end

	// latched request
	logic                 mode_q, hit_q;
	logic [SET_W-1:0]     set_q;
	logic [WAY_W-1:0]     way_q;
	logic [SIG_BITS-1:0]  sig_q;
	logic [HASH_BITS-1:0] hash_q;
	logic [63:0]          addr_q;
	logic [11:0]          sig_ext;
	logic [15:0]          hash_ext;

	assign sig_ext  = {6'b0, req.pc_signature};
	assign hash_ext = {8'b0, req.line_hash};

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			mode_q <= req.mode;
			hit_q  <= req.was_hit;
			set_q  <= SET_W'(red_mod(req.set_index, NUM_SETS));
			way_q  <= WAY_W'(red_mod({7'b0, req.way_index}, NUM_WAYS));
			sig_q  <= sig_ext[SIG_BITS-1:0];
			hash_q <= hash_ext[HASH_BITS-1:0];
			addr_q <= req.line_address;
		end
	end

	// access count and decay mark
	logic [63:0] total_q, mark_q, since;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			mark_q  <= '0;
		end else begin
			if (cmd.latch && (req.mode == MODE_UPDATE)) total_q <= total_q + 64'd1;
			if (cmd.sweep_go) mark_q <= total_q;
		end
	end

	assign since = total_q - mark_q;

	// sweep engine: clear after reset, decrement on decay
	logic             act_q, clr_q, wdead_s1, wsig_s1;
	logic [CNT_W-1:0] cnt_q, wa_s1;
	logic             clearing, sweeping, in_sets, in_sigs;
	logic [SET_W-1:0] eng_set;
	logic [SIG_BITS-1:0] eng_sig;

	assign clearing = act_q && clr_q;
	assign sweeping = act_q && !clr_q;
	assign in_sets  = cnt_q < CNT_W'(NUM_SETS);
	assign in_sigs  = cnt_q < CNT_W'(NUM_SIGS);
	assign eng_set  = cnt_q[SET_W-1:0];
	assign eng_sig  = cnt_q[SIG_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b1;
			clr_q    <= 1'b1;
			cnt_q    <= '0;
			wdead_s1 <= 1'b0;
			wsig_s1  <= 1'b0;
		end else begin
			wdead_s1 <= sweeping && in_sets;
			wsig_s1  <= sweeping && in_sigs;
			if (cmd.sweep_go) begin
				act_q <= 1'b1;
				clr_q <= 1'b0;
				cnt_q <= '0;
			end else if (act_q) begin
				if (cnt_q == CNT_W'(SWEEP_LEN - 1)) act_q <= 1'b0;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= cnt_q;
	end

	// stores
	logic [NUM_WAYS-1:0][1:0]           rrpv_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][1:0]           dead_mem [NUM_SETS];
	logic [NUM_WAYS-1:0][HASH_BITS-1:0] hash_mem [NUM_SETS];
	logic [63:0]                        paddr_mem [NUM_SETS];
	logic [63:0]                        pstride_mem [NUM_SETS];
	logic [2:0]                         scnt_mem [NUM_SETS];
	logic [1:0]                         sig_mem [NUM_SIGS];

	logic [NUM_WAYS-1:0][1:0]           rrpv_rd_q, dead_rd_q;
	logic [NUM_WAYS-1:0][HASH_BITS-1:0] hash_rd_q;
	logic [63:0]                        paddr_rd_q, pstride_rd_q;
	logic [2:0]                         scnt_rd_q;
	logic [1:0]                         sig_rd_q;

	// victim selection
	logic [1:0]               max_r, age;
	logic [NUM_WAYS-1:0][1:0] aged;
	logic [WAY_W-1:0]         vic;
	logic [31:0]              vic_ext;

	always_comb begin
		max_r = 2'd0;
		vic   = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (rrpv_rd_q[w] > max_r) max_r = rrpv_rd_q[w];
		end
		age = RRPV_DISTANT - max_r;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			aged[w] = rrpv_rd_q[w] + age;
			if (rrpv_rd_q[w] == max_r) vic = WAY_W'(w);
		end
	end

	assign vic_ext = 32'(vic);

	// update, first stage
	logic [1:0]  sig_new, dead_old, dead_new;
	logic        hot;
	logic [63:0] stride;
	logic [1:0]  sig_new_s1, dead_new_s1;
	logic        hot_s1, prev_nz_s1;
	logic [63:0] stride_s1;

	always_comb begin
		dead_old = dead_rd_q[way_q];
		if (hit_q) begin
			sig_new  = (sig_rd_q < CTR_MAX) ? sig_rd_q + 2'd1 : sig_rd_q;
			dead_new = 2'd0;
		end else begin
			sig_new  = (sig_rd_q != 2'd0) ? sig_rd_q - 2'd1 : sig_rd_q;
			dead_new = (dead_old < CTR_MAX) ? dead_old + 2'd1 : dead_old;
		end
		hot = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if ((WAY_W'(w) != way_q) && (hash_rd_q[w] == hash_q)) hot = 1'b1;
		end
	end

	assign stride = addr_q - paddr_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.upd_s1) begin
			sig_new_s1  <= sig_new;
			dead_new_s1 <= dead_new;
			hot_s1      <= hot;
			stride_s1   <= stride;
			prev_nz_s1  <= (paddr_rd_q != 64'd0);
		end
	end

	// update, final stage: stream step and insertion value
	logic        same;
	logic [2:0]  scnt_new;
	logic        streaming, any_hot;
	logic [1:0]  ins;
	logic [NUM_WAYS-1:0][1:0]           rrpv_row_new, dead_row_new, dead_dec;
	logic [NUM_WAYS-1:0][HASH_BITS-1:0] hash_row_new;

	always_comb begin
		same     = (stride_s1 == pstride_rd_q) && (stride_s1 != 64'd0);
		scnt_new = scnt_rd_q;
		if (prev_nz_s1) begin
			if (same) scnt_new = (scnt_rd_q < STREAM_MAX) ? scnt_rd_q + 3'd1 : scnt_rd_q;
			else      scnt_new = (scnt_rd_q != 3'd0) ? scnt_rd_q - 3'd1 : scnt_rd_q;
		end
		streaming = (scnt_new >= thr_q);
		any_hot   = hot_s1 || (sig_new_s1 >= CTR_HOT);
		if (streaming)                  ins = any_hot ? RRPV_NEAR : RRPV_DISTANT;
		else if (dead_new_s1 >= CTR_HOT) ins = RRPV_DISTANT;
		else if (any_hot)               ins = RRPV_NEAR;
		else                            ins = RRPV_LONG;
		rrpv_row_new        = rrpv_rd_q;
		rrpv_row_new[way_q] = ins;
		dead_row_new        = dead_rd_q;
		dead_row_new[way_q] = dead_new_s1;
		hash_row_new        = hash_rd_q;
		hash_row_new[way_q] = hash_q;
		for (int w = 0; w < NUM_WAYS; w++) begin
			dead_dec[w] = (dead_rd_q[w] != 2'd0) ? dead_rd_q[w] - 2'd1 : 2'd0;
		end
	end

	// store read ports
	logic [SET_W-1:0]    dead_ra;
	logic [SIG_BITS-1:0] sig_ra;

	assign dead_ra = sweeping ? eng_set : set_q;
	assign sig_ra  = sweeping ? eng_sig : sig_q;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rrpv_rd_q    <= rrpv_mem[set_q];
			hash_rd_q    <= hash_mem[set_q];
			paddr_rd_q   <= paddr_mem[set_q];
			pstride_rd_q <= pstride_mem[set_q];
			scnt_rd_q    <= scnt_mem[set_q];
		end
		if (cmd.rd || (sweeping && in_sets)) dead_rd_q <= dead_mem[dead_ra];
		if (cmd.rd || (sweeping && in_sigs)) sig_rd_q  <= sig_mem[sig_ra];
	end

	// store write ports
	logic                clr_set, clr_sig;
	logic [SET_W-1:0]    row_wa, dead_wa;
	logic [SIG_BITS-1:0] sig_wa;

	assign clr_set = clearing && in_sets;
	assign clr_sig = clearing && in_sigs;
	assign row_wa  = clearing ? eng_set : set_q;
	assign dead_wa = clearing ? eng_set : (wdead_s1 ? wa_s1[SET_W-1:0] : set_q);
	assign sig_wa  = clearing ? eng_sig : (wsig_s1 ? wa_s1[SIG_BITS-1:0] : sig_q);

	always_ff @(posedge clk) begin
		if (clr_set || cmd.victim_fin || cmd.upd_fin)
			rrpv_mem[row_wa] <= clearing ? '0 : (cmd.victim_fin ? aged : rrpv_row_new);
		if (clr_set || wdead_s1 || cmd.upd_fin)
			dead_mem[dead_wa] <= clearing ? '0 : (wdead_s1 ? dead_dec : dead_row_new);
		if (clr_set || cmd.upd_fin) begin
			hash_mem[row_wa]    <= clearing ? '0 : hash_row_new;
			paddr_mem[row_wa]   <= clearing ? '0 : addr_q;
			pstride_mem[row_wa] <= clearing ? '0 : stride_s1;
			scnt_mem[row_wa]    <= clearing ? '0 : scnt_new;
		end
		if (clr_sig || wsig_s1 || cmd.upd_fin)
			sig_mem[sig_wa] <= clearing ? 2'd0 :
				(wsig_s1 ? ((sig_rd_q != 2'd0) ? sig_rd_q - 2'd1 : 2'd0) : sig_new_s1);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else         result_valid <= cmd.victim_fin || cmd.upd_fin;
	end

	always_ff @(posedge clk) begin
		if (cmd.victim_fin) begin
			result.victim_way    <= vic_ext[3:0];
			result.set_streaming <= (scnt_rd_q >= thr_q);
			result.inserted_rrpv <= 2'd0;
		end else if (cmd.upd_fin) begin
			result.victim_way    <= 4'd0;
			result.set_streaming <= streaming;
			result.inserted_rrpv <= ins;
		end
	end

	assign stat.mode_upd  = (mode_q == MODE_UPDATE);
	assign stat.decay_due = (since >= {32'b0, period_q});
	assign stat.eng_busy  = act_q || wdead_s1 || wsig_s1;

endmodule

`default_nettype wire

FILE: hdl/ship_rrip_stream_deadblock_repl.sv
// ----------------------------------------------------------------------------
// ship_rrip_stream_deadblock_repl
// Cache replacement policy: RRIP ageing, signature and dead-block counters,
// per-set stride stream detection.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A victim request
// passes dispatch, store read and victim write-back; an update has a first
// update stage and a final write-back after its store read. Each row store
// is read once per request; an update writes each back once, a victim
// request only the RRPV row. An update that reaches the decay period first
// runs a sweep over all sets and signatures. After reset the stores are
// cleared and busy stays high until the clear is done. Each result is shown
// for one cycle on result_valid; the receiver cannot stall. Configuration
// writes are always ready and should only be made while the block is idle.
`default_nettype none

module ship_rrip_stream_deadblock_repl #(
	parameter int NUM_SETS  = 2048,
	parameter int NUM_WAYS  = 16,
	parameter int SIG_BITS  = 6,
	parameter int HASH_BITS = 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  shiprr_pkg::req_t    req,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire  [7:0]          cfg_index,
	input  wire  [31:0]         cfg_data,
	output logic                result_valid,
	output shiprr_pkg::res_t    result
);
	import shiprr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	shiprr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	shiprr_dpath #(
		.NUM_SETS  (NUM_SETS),
		.NUM_WAYS  (NUM_WAYS),
		.SIG_BITS  (SIG_BITS),
		.HASH_BITS (HASH_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result       (result)
	);

	// result strobe lasts one cycle
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("result strobe held");

	// an accepted request makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("not busy after accept");

	// no result in the cycle after acceptance
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !result_valid) else $error("early result");

endmodule

`default_nettype wire
